// ===== rtl/core/pls_pkg.sv =====
// Package for the locked sample extractor: item types, field widths and constants.
// Used by the channel interfaces and by the top level. Depends on nothing.
package pls_pkg;

   localparam int BYTE_BITS   = 8;
   localparam int SAMPLE_BITS = 14;
   localparam int HALF_BITS   = 7;
   localparam int WORD_BITS   = 32;
   localparam int FILL_BITS   = 7;

   // taps of the 32-bit sequence generator
   localparam logic [WORD_BITS-1:0] SEQ_TAPS = 32'h8040_1020;
   // bytes needed to fill both interleaved histories
   localparam logic [FILL_BITS-1:0] FILL_FULL = 7'd64;
   // fill count after a failing pair seeds the search
   localparam logic [FILL_BITS-1:0] FILL_SEED = 7'd2;
   localparam logic [WORD_BITS-1:0] REQUIRED_RESET = 32'd16777280;

   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_REPORT = 1'b1
   } kind_type;

   // one result item as held in the output queue; enough is formed on read
   typedef struct packed {
      kind_type               kind;
      logic [SAMPLE_BITS-1:0] sample;
      logic [WORD_BITS-1:0]   run_length;
      logic [WORD_BITS-1:0]   best_length;
      logic [WORD_BITS-1:0]   best_offset;
      logic                   last;
   } result_type;

endpackage

// ===== rtl/core/pls_req_if.sv =====
// Input channel of the locked sample extractor: one raw dump byte per item.
// Depends on pls_pkg for the field widths.
interface pls_req_if;
   logic                           valid;
   logic                           ready;
   logic [pls_pkg::BYTE_BITS-1:0]  dump_byte;
   logic                           end_of_dump;

   modport source (output valid, output dump_byte, output end_of_dump, input ready);
   modport sink   (input valid, input dump_byte, input end_of_dump, output ready);
endinterface

// ===== rtl/core/pls_rsp_if.sv =====
// Result channel of the locked sample extractor: samples and run-closed reports.
// Depends on pls_pkg for the field widths.
interface pls_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             kind;
   logic [pls_pkg::SAMPLE_BITS-1:0]  sample;
   logic [pls_pkg::WORD_BITS-1:0]    run_length;
   logic [pls_pkg::WORD_BITS-1:0]    best_length;
   logic [pls_pkg::WORD_BITS-1:0]    best_offset;
   logic                             enough;
   logic                             last;

   modport source (output valid, output kind, output sample, output run_length,
                   output best_length, output best_offset, output enough,
                   output last, input ready);
   modport sink   (input valid, input kind, input sample, input run_length,
                   input best_length, input best_offset, input enough,
                   input last, output ready);
endinterface

// ===== rtl/core/prbs_locked_sample_extractor.sv =====
// Top level of the locked sample extractor: sequence lock, pair check, run tracking.
// Depends on pls_pkg, pls_req_if and pls_rsp_if.
//
// Usage:
//   req_ch carries one raw dump byte per item: bit 7 is the doubled sequence bit,
//   bits 6..0 half a sample; end_of_dump marks the final byte of a dump.
//   rsp_ch carries result items: a 14-bit sample for every good byte pair, and a
//   run-closed report (run length, best run so far, its start, enough flag).
//   A byte yields zero, one or two items; last flags the final one of a byte.
//   csr_write_enable/csr_write_data set the required run length; write it
//   only while no item is in flight.
// Timing:
//   An accepted byte is held in the input register; the whole state
//   update then runs from that register and pushes its items into a
//   four-entry result queue. The first result is valid once the byte has
//   passed the input register and been written into the queue.
//   One byte per cycle is sustained as long as results drain at one per cycle;
//   the queue needs room for two items before a byte is processed, so bytes
//   that yield two items make the queue grow and can hold the input back.
//   Reset clears the stream state and the queue; the required length returns
//   to 16777280. After the final byte of a dump the stream state is cleared
//   and the next byte starts a new dump at offset 0.
//   When the receiver stalls, the queue fills and req_ch.ready drops.
module prbs_locked_sample_extractor #(
   parameter int OFFSET_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   pls_req_if.sink                        req_ch,
   pls_rsp_if.source                      rsp_ch,
   input  logic                           csr_write_enable,
   input  logic [pls_pkg::WORD_BITS-1:0]  csr_write_data
);
   import pls_pkg::*;

   localparam int EXT_BITS   = (OFFSET_BITS > WORD_BITS + 1) ? OFFSET_BITS : WORD_BITS + 1;
   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
   localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);
   localparam logic [Q_CNT_BITS-1:0] Q_ROOM_LIMIT = Q_CNT_BITS'(Q_DEPTH - 2);
   localparam logic [Q_CNT_BITS-1:0] Q_FULL_COUNT = Q_CNT_BITS'(Q_DEPTH);

   // configuration
   logic [WORD_BITS-1:0]    required_ff;

   // input register
   logic                    in_valid_ff;
   logic [BYTE_BITS-1:0]    in_byte_ff;
   logic                    in_end_ff;

   // stream state
   logic                    locked_ff, locked_in;
   logic [FILL_BITS-1:0]    fill_ff, fill_in;
   logic [WORD_BITS-1:0]    even_ff, even_in;
   logic [WORD_BITS-1:0]    odd_ff, odd_in;
   logic [WORD_BITS-1:0]    track_ff, track_in;
   logic                    half_ff, half_in;
   logic [BYTE_BITS-1:0]    held_ff, held_in;
   logic [OFFSET_BITS-1:0]  offset_ff, offset_in;
   logic [OFFSET_BITS-1:0]  run_start_ff, run_start_in;
   logic [WORD_BITS-1:0]    best_len_ff, best_len_in;
   logic [OFFSET_BITS-1:0]  best_start_ff, best_start_in;

   // result queue
   result_type              queue_mem [Q_DEPTH];
   logic [Q_PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_BITS-1:0]   count_ff;

   logic                    proc_fire;
   logic                    pop;
   logic [1:0]              push_n;
   result_type              entry0, entry1;

   assign proc_fire    = in_valid_ff && (count_ff <= Q_ROOM_LIMIT);
   assign req_ch.ready = !in_valid_ff || proc_fire;

   // ------------------------------------------------------------------
   // Per-byte update
   // ------------------------------------------------------------------
   always_comb begin
      logic                    bit_now;
      logic                    par_even;
      logic                    par_track;
      logic                    held_bit;
      logic [WORD_BITS-1:0]    nxt_even;
      logic [OFFSET_BITS-1:0]  idx_inc;
      logic [OFFSET_BITS-1:0]  span_end;
      logic [OFFSET_BITS-1:0]  diff;
      logic [EXT_BITS-1:0]     diff_ext;
      logic [EXT_BITS-1:0]     best_ext;
      logic [WORD_BITS-1:0]    len32;
      logic                    closing;
      logic                    good_pair;
      logic                    fail_pair;
      logic                    is_end;
      result_type              report;
      result_type              sample_item;

      bit_now   = in_byte_ff[BYTE_BITS-1];
      is_end    = in_end_ff;
      par_even  = ^(even_ff & SEQ_TAPS);
      par_track = ^(track_ff & SEQ_TAPS);
      held_bit  = held_ff[BYTE_BITS-1];
      nxt_even  = {even_ff[WORD_BITS-2:0], bit_now};
      idx_inc   = (offset_ff == '1) ? offset_ff : offset_ff + OFFSET_BITS'(1);

      locked_in     = locked_ff;
      fill_in       = fill_ff;
      even_in       = even_ff;
      odd_in        = odd_ff;
      track_in      = track_ff;
      half_in       = half_ff;
      held_in       = held_ff;
      offset_in     = offset_ff;
      run_start_in  = run_start_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;

      closing   = 1'b0;
      good_pair = 1'b0;
      fail_pair = 1'b0;
      span_end  = offset_ff;

      if (!locked_ff) begin
         if (fill_ff < FILL_FULL) begin
            if (!fill_ff[0]) begin
               even_in = {even_ff[WORD_BITS-2:0], bit_now};
            end else begin
               odd_in = {odd_ff[WORD_BITS-2:0], bit_now};
            end
            fill_in = fill_ff + FILL_BITS'(1);
         end else if (nxt_even == odd_ff && bit_now == par_even) begin
            // lock: run starts after the locking byte; a lock on the final
            // byte closes at once with length zero
            track_in     = nxt_even;
            locked_in    = 1'b1;
            half_in      = 1'b0;
            run_start_in = idx_inc;
            closing      = is_end;
         end else begin
            even_in = odd_ff;
            odd_in  = nxt_even;
         end
      end else if (!half_ff) begin
         held_in = in_byte_ff;
         half_in = 1'b1;
         closing = is_end;
      end else begin
         half_in  = 1'b0;
         track_in = {track_ff[WORD_BITS-2:0], held_bit};
         if (held_bit == bit_now && held_bit == par_track) begin
            good_pair = 1'b1;
            closing   = is_end;
            span_end  = idx_inc;
         end else begin
            // failing pair seeds a new search as its first two fill bytes
            fail_pair = 1'b1;
            closing   = 1'b1;
            locked_in = 1'b0;
            even_in   = {{(WORD_BITS-1){1'b0}}, held_bit};
            odd_in    = {{(WORD_BITS-1){1'b0}}, bit_now};
            fill_in   = FILL_SEED;
         end
      end

      // run length in bytes, never below zero, saturated to 32 bits
      diff = (span_end >= run_start_ff) ? span_end - run_start_ff : '0;
      if (fail_pair && diff != '0) begin
         diff = diff - OFFSET_BITS'(1);
      end
      if (!locked_ff) begin
         diff = '0;
      end
      diff_ext = EXT_BITS'(diff);
      len32    = (|diff_ext[EXT_BITS-1:WORD_BITS]) ? '1 : diff_ext[WORD_BITS-1:0];

      sample_item.kind        = KIND_SAMPLE;
      sample_item.sample      = {held_ff[HALF_BITS-1:0], in_byte_ff[HALF_BITS-1:0]};
      sample_item.run_length  = '0;
      sample_item.best_length = best_len_ff;
      best_ext                = EXT_BITS'(best_start_ff);
      sample_item.best_offset = (|best_ext[EXT_BITS-1:WORD_BITS]) ? '1
                                : best_ext[WORD_BITS-1:0];
      sample_item.last        = 1'b0;

      // strictly longer runs replace the best
      if (closing && len32 > best_len_ff) begin
         best_len_in   = len32;
         best_start_in = run_start_in;
      end

      report.kind        = KIND_REPORT;
      report.sample      = '0;
      report.run_length  = closing ? len32 : '0;
      report.best_length = best_len_in;
      best_ext           = EXT_BITS'(best_start_in);
      report.best_offset = (|best_ext[EXT_BITS-1:WORD_BITS]) ? '1
                           : best_ext[WORD_BITS-1:0];
      report.last        = 1'b1;

      if (good_pair) begin
         entry0 = sample_item;
         entry1 = report;
         if (closing || is_end) begin
            push_n = 2'd2;
         end else begin
            push_n      = 2'd1;
            entry0.last = 1'b1;
         end
      end else begin
         entry0 = report;
         entry1 = report;
         push_n = (closing || is_end) ? 2'd1 : 2'd0;
      end

      if (!proc_fire) begin
         push_n = 2'd0;
      end

      // end of dump: all stream state back to reset values
      if (is_end) begin
         locked_in     = 1'b0;
         fill_in       = '0;
         even_in       = '0;
         odd_in        = '0;
         track_in      = '0;
         half_in       = 1'b0;
         held_in       = '0;
         offset_in     = '0;
         run_start_in  = '0;
         best_len_in   = '0;
         best_start_in = '0;
      end else begin
         offset_in = idx_inc;
      end
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         required_ff   <= REQUIRED_RESET;
         in_valid_ff   <= 1'b0;
         locked_ff     <= 1'b0;
         fill_ff       <= '0;
         even_ff       <= '0;
         odd_ff        <= '0;
         track_ff      <= '0;
         half_ff       <= 1'b0;
         held_ff       <= '0;
         offset_ff     <= '0;
         run_start_ff  <= '0;
         best_len_ff   <= '0;
         best_start_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            required_ff <= csr_write_data;
         end
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (proc_fire) begin
            locked_ff     <= locked_in;
            fill_ff       <= fill_in;
            even_ff       <= even_in;
            odd_ff        <= odd_in;
            track_ff      <= track_in;
            half_ff       <= half_in;
            held_ff       <= held_in;
            offset_ff     <= offset_in;
            run_start_ff  <= run_start_in;
            best_len_ff   <= best_len_in;
            best_start_ff <= best_start_in;
         end
      end
   end

   // input payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_byte_ff <= req_ch.dump_byte;
         in_end_ff  <= req_ch.end_of_dump;
      end
   end

   // ------------------------------------------------------------------
   // Result queue
   // ------------------------------------------------------------------
   assign pop = rsp_ch.valid && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         queue_mem[wr_ptr_ff] <= entry0;
      end
      if (push_n == 2'd2) begin
         queue_mem[wr_ptr_ff + Q_PTR_BITS'(1)] <= entry1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + Q_PTR_BITS'(push_n);
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + Q_PTR_BITS'(1);
         end
         count_ff <= count_ff + Q_CNT_BITS'(push_n) - Q_CNT_BITS'(pop);
      end
   end

   always_comb begin
      result_type head;
      head               = queue_mem[rd_ptr_ff];
      rsp_ch.valid       = (count_ff != '0);
      rsp_ch.kind        = head.kind;
      rsp_ch.sample      = head.sample;
      rsp_ch.run_length  = head.run_length;
      rsp_ch.best_length = head.best_length;
      rsp_ch.best_offset = head.best_offset;
      // the user must change the register only while nothing is queued; the block does not enforce this
      rsp_ch.enough      = (head.best_length >= required_ff);
      rsp_ch.last        = head.last;
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_FULL_COUNT)
      else $error("result queue overflow");

   a_locked_filled: assert property (@(posedge clock) disable iff (reset)
      locked_ff |-> fill_ff == FILL_FULL)
      else $error("locked without full histories");

   a_end_reports: assert property (@(posedge clock) disable iff (reset)
      proc_fire && in_end_ff |-> push_n != 2'd0)
      else $error("final byte produced no report");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      proc_fire && in_end_ff |=> offset_ff == '0 && !locked_ff && best_len_ff == '0)
      else $error("stream state not cleared after final byte");

endmodule

// ===== dv/tb_prbs_locked_sample_extractor.sv =====
// Self-checking testbench for prbs_locked_sample_extractor: doubled-sequence
// dumps, pair checks, run tracking and the required-length register.
// Depends on pls_pkg, pls_req_if, pls_rsp_if and the top level RTL.
`timescale 1ns / 100ps

module tb_prbs_locked_sample_extractor;
   import pls_pkg::*;

   localparam int OFFSET_BITS    = 32;
   localparam int RANDOM_BYTES   = 150;
   // a byte reaches the result queue through the input register; leave margin
   localparam int DRAIN_CYCLES   = 8;
   // cycles with no item accepted on either side before giving up
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

   typedef struct packed {
      kind_type               kind;
      logic [SAMPLE_BITS-1:0] sample;
      logic [WORD_BITS-1:0]   run_length;
      logic [WORD_BITS-1:0]   best_length;
      logic [WORD_BITS-1:0]   best_offset;
      logic                   enough;
      logic                   last;
   } check_item_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_enable;
   logic [WORD_BITS-1:0] csr_write_data;

   pls_req_if req_ch ();
   pls_rsp_if rsp_ch ();

   prbs_locked_sample_extractor #(
      .OFFSET_BITS (OFFSET_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Predicted stream state: mirrors the block's search / locked machine.
   logic                   in_lock;
   logic [FILL_BITS-1:0]   fill_cnt;
   logic [WORD_BITS-1:0]   hist_even;
   logic [WORD_BITS-1:0]   hist_odd;
   logic [WORD_BITS-1:0]   seq_state;
   logic                   second_half;
   logic [BYTE_BITS-1:0]   first_byte;
   logic [OFFSET_BITS-1:0] cur_offset;
   logic [OFFSET_BITS-1:0] run_begin;
   logic [WORD_BITS-1:0]   top_len;
   logic [OFFSET_BITS-1:0] best_begin;
   logic [WORD_BITS-1:0]   req_len = REQUIRED_RESET;
   // good pairs since the last lock; steers where stimulus breaks a run
   int                     run_pairs;

   check_item_type expected_results[$];
   int          error_count  = 0;
   int          bytes_sent   = 0;
   int          quiet_cycles = 0;
   // cleared for stretches where neither side idles
   bit          idle_on      = 1'b1;

   initial begin
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic logic [OFFSET_BITS-1:0] span(input logic [OFFSET_BITS-1:0] a,
                                                   input logic [OFFSET_BITS-1:0] b);
      return (a >= b) ? a - b : '0;
   endfunction

   function automatic logic [OFFSET_BITS-1:0] next_offset(input logic [OFFSET_BITS-1:0] x);
      return (x < OFFSET_MAX) ? x + OFFSET_BITS'(1) : OFFSET_MAX;
   endfunction

   function automatic logic [WORD_BITS-1:0] sat_word(input logic [63:0] v);
      return (v > 64'hFFFF_FFFF) ? '1 : v[WORD_BITS-1:0];
   endfunction

   // Snapshot of the best run at the moment a result is produced.
   function automatic check_item_type make_result(input kind_type k,
                                                  input logic [SAMPLE_BITS-1:0] s,
                                                  input logic [WORD_BITS-1:0] rl);
      check_item_type r;
      r.kind        = k;
      r.sample      = s;
      r.run_length  = rl;
      r.best_length = top_len;
      r.best_offset = sat_word(64'(best_begin));
      r.enough      = (top_len >= req_len);
      r.last        = 1'b0;
      return r;
   endfunction

   task automatic clear_stream();
      in_lock     = 1'b0;
      fill_cnt    = '0;
      hist_even   = '0;
      hist_odd    = '0;
      seq_state   = '0;
      second_half = 1'b0;
      first_byte  = '0;
      cur_offset  = '0;
      run_begin   = '0;
      top_len     = '0;
      best_begin  = '0;
      run_pairs   = 0;
   endtask

   // Work out the result items of one accepted byte and queue them.
   task automatic predict_byte(input logic [BYTE_BITS-1:0] b, input logic eod);
      check_item_type         outs [2];
      int                     n;
      logic                   bit_in;
      logic                   h;
      logic [WORD_BITS-1:0]   pred;
      logic [WORD_BITS-1:0]   nxt;
      logic [OFFSET_BITS-1:0] idx;
      logic [OFFSET_BITS-1:0] len;
      logic                   closing;
      n       = 0;
      bit_in  = b[7];
      idx     = cur_offset;
      len     = '0;
      closing = 1'b0;
      if (!in_lock) begin
         if (fill_cnt < FILL_FULL) begin
            // alternate bytes feed the two histories
            if (fill_cnt[0] == 1'b0) begin
               hist_even = {hist_even[WORD_BITS-2:0], bit_in};
            end else begin
               hist_odd = {hist_odd[WORD_BITS-2:0], bit_in};
            end
            fill_cnt = fill_cnt + FILL_BITS'(1);
         end else begin
            nxt  = {hist_even[WORD_BITS-2:0], bit_in};
            pred = {hist_even[WORD_BITS-2:0], ^(hist_even & SEQ_TAPS)};
            if (nxt == hist_odd && nxt == pred) begin
               seq_state   = nxt;
               in_lock     = 1'b1;
               second_half = 1'b0;
               run_begin   = next_offset(idx);
               run_pairs   = 0;
            end else begin
               hist_even = hist_odd;
               hist_odd  = nxt;
            end
         end
         // locking on the final byte closes an empty run
         if (in_lock && eod) closing = 1'b1;
      end else if (!second_half) begin
         first_byte  = b;
         second_half = 1'b1;
         // held unpaired byte is not part of the run
         if (eod) begin
            closing = 1'b1;
            len     = span(idx, run_begin);
         end
      end else begin
         h           = first_byte[7];
         pred        = {seq_state[WORD_BITS-2:0], ^(seq_state & SEQ_TAPS)};
         nxt         = {seq_state[WORD_BITS-2:0], h};
         second_half = 1'b0;
         seq_state   = nxt;
         if (h == bit_in && pred == nxt) begin
            outs[n] = make_result(KIND_SAMPLE, {first_byte[HALF_BITS-1:0], b[HALF_BITS-1:0]},
                                  '0);
            n++;
            run_pairs++;
            if (eod) begin
               closing = 1'b1;
               len     = span(next_offset(idx), run_begin);
            end
         end else begin
            // failing pair: run excludes it, and it seeds the next search
            closing = 1'b1;
            len     = span(idx, run_begin);
            if (len != '0) len = len - OFFSET_BITS'(1);
            in_lock   = 1'b0;
            hist_even = {{(WORD_BITS-1){1'b0}}, h};
            hist_odd  = {{(WORD_BITS-1){1'b0}}, bit_in};
            fill_cnt  = FILL_SEED;
         end
      end

      if (closing) begin
         // ties keep the earlier best run
         if (sat_word(64'(len)) > top_len) begin
            top_len    = sat_word(64'(len));
            best_begin = run_begin;
         end
         outs[n] = make_result(KIND_REPORT, '0, sat_word(64'(len)));
         n++;
      end else if (eod) begin
         outs[n] = make_result(KIND_REPORT, '0, '0);
         n++;
      end
      if (n > 0) outs[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_results.push_back(outs[i]);

      if (eod) begin
         clear_stream();
      end else begin
         cur_offset = next_offset(cur_offset);
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus side
   // ------------------------------------------------------------------
   // Called in a clock-edge time step; returns in the step of acceptance.
   task automatic send_item(input logic [BYTE_BITS-1:0] b, input logic eod);
      int gap;
      gap = idle_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.dump_byte   <= b;
      req_ch.end_of_dump <= eod;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predict_byte(b, eod);
      bytes_sent++;
   endtask

   // Stop sending and hold off until every expected item has come back.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_required(input logic [WORD_BITS-1:0] value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      req_len = value;
   endtask

   // One dump of a doubled sequence with random half samples.
   //   half_phase: start on the second copy of a bit
   //   fail_after: break a run after this many good pairs (negative: never)
   //   noise_pm:   per-mille chance of flipping any sequence bit
   //   end_at_fail: end the dump on the byte that breaks the run
   task automatic send_dump(input logic [WORD_BITS-1:0] seed, input bit half_phase,
                            input int n_bytes, input int fail_after, input int noise_pm,
                            input bit end_at_fail, input bit with_end);
      logic [WORD_BITS-1:0] lfsr;
      logic                 cur_bit;
      logic                 fb;
      int                   copies;
      bit                   flip_first;
      bit                   flip;
      bit                   end_now;
      logic [HALF_BITS-1:0] half;
      lfsr       = seed;
      fb         = ^(lfsr & SEQ_TAPS);
      lfsr       = {lfsr[WORD_BITS-2:0], fb};
      cur_bit    = fb;
      copies     = half_phase ? 1 : 2;
      flip_first = end_at_fail ? 1'b0 : 1'($urandom_range(0, 1));
      for (int i = 0; i < n_bytes; i++) begin
         flip = (fail_after >= 0) && in_lock && (run_pairs == fail_after) &&
                (second_half != flip_first);
         if ($urandom_range(0, 999) < noise_pm) flip = 1'b1;
         case ($urandom_range(0, 7))
            0:       half = '0;
            1:       half = '1;
            default: half = HALF_BITS'($urandom_range(0, 127));
         endcase
         end_now = end_at_fail && flip && in_lock && second_half;
         send_item({cur_bit ^ flip, half}, (with_end && i == n_bytes - 1) || end_now);
         if (end_now) break;
         copies--;
         if (copies == 0) begin
            fb      = ^(lfsr & SEQ_TAPS);
            lfsr    = {lfsr[WORD_BITS-2:0], fb};
            cur_bit = fb;
            copies  = 2;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Result side: random stalls, each item checked against the oldest
   // expectation.
   // ------------------------------------------------------------------
   task automatic check_field(input string name, input logic [WORD_BITS-1:0] want,
                              input logic [WORD_BITS-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   initial begin
      int             stall;
      check_item_type want;
      rsp_ch.ready <= 1'b0;
      @(posedge clock iff reset === 1'b0);
      forever begin
         stall = idle_on ? $urandom_range(0, 16) : 0;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         if (expected_results.size() == 0) begin
            $error("result item with none expected: kind %0d", rsp_ch.kind);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("kind", WORD_BITS'(want.kind), WORD_BITS'(rsp_ch.kind));
            check_field("sample", WORD_BITS'(want.sample), WORD_BITS'(rsp_ch.sample));
            check_field("run_length", want.run_length, rsp_ch.run_length);
            check_field("best_length", want.best_length, rsp_ch.best_length);
            check_field("best_offset", want.best_offset, rsp_ch.best_offset);
            check_field("enough", WORD_BITS'(want.enough), WORD_BITS'(rsp_ch.enough));
            check_field("last", WORD_BITS'(want.last), WORD_BITS'(rsp_ch.last));
         end
      end
   end

   // Watchdog: a correct run never goes this long without a handshake.
   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_prbs_locked_sample_extractor: FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // Byte extremes while still searching; a dump ended in search mode
   // reports a zero-length run, and a one-byte dump does the same.
   task automatic test_search_extremes();
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h80, 1'b0);
      send_item(8'h7F, 1'b0);
      send_item(8'h55, 1'b0);
      send_item(8'hAA, 1'b0);
      send_item(8'h01, 1'b1);
      send_item(8'hFF, 1'b1);
      wait_drained();
   endtask

   // Lock from both byte phases; one dump ends on a complete pair (sample
   // plus report), the other with an unpaired byte held.
   task automatic test_lock_and_samples();
      send_dump($urandom, 1'b1, 73, -1, 0, 1'b0, 1'b1);
      send_dump($urandom, 1'b0, 73, -1, 0, 1'b0, 1'b1);
      // all-zero sequence is a valid (degenerate) stream
      send_dump('0, 1'b0, 70, -1, 0, 1'b0, 1'b1);
      wait_drained();
   endtask

   // With the half phase, lock happens exactly on byte 64: end the dump there.
   task automatic test_lock_on_final_byte();
      send_dump($urandom, 1'b1, 65, -1, 0, 1'b0, 1'b1);
      wait_drained();
   endtask

   // Runs broken after a fixed pair count give equal lengths, so the first
   // best run must survive the ties; then a pair failing on the final byte.
   task automatic test_failing_pairs();
      send_dump($urandom, 1'b0, 170, 5, 0, 1'b0, 1'b1);
      send_dump($urandom, 1'b1, 200, 2, 0, 1'b1, 1'b1);
      wait_drained();
   endtask

   // Required length at zero, at its maximum, and low enough that the
   // enough flag turns on partway through a dump.
   task automatic test_required_extremes();
      write_required('0);
      send_dump($urandom, 1'b1, 80, 4, 0, 1'b0, 1'b1);
      write_required('1);
      send_dump($urandom, 1'b0, 70, -1, 0, 1'b0, 1'b1);
      write_required(32'd12);
      send_dump($urandom, 1'b1, 110, 8, 0, 1'b0, 1'b1);
      write_required(REQUIRED_RESET);
   endtask

   // Mostly well-formed dumps with random content, plus noise dumps, broken
   // runs, dumps that run into the next without an end, idle-free stretches,
   // register changes and full drains in between.
   task automatic test_random_stream();
      int                   start;
      int                   pick;
      int                   n;
      logic [BYTE_BITS-1:0] b;
      logic [WORD_BITS-1:0] value;
      start = bytes_sent;
      while (bytes_sent - start < RANDOM_BYTES) begin
         pick    = $urandom_range(0, 19);
         idle_on = ($urandom_range(0, 3) != 0);
         if (pick == 0) begin
            case ($urandom_range(0, 4))
               0:       value = '0;
               1:       value = '1;
               2:       value = REQUIRED_RESET;
               3:       value = $urandom_range(0, 300);
               default: value = $urandom;
            endcase
            write_required(value);
         end else if (pick == 1) begin
            wait_drained();
         end else if (pick <= 3) begin
            n = $urandom_range(1, 40);
            for (int i = 0; i < n; i++) begin
               b = BYTE_BITS'($urandom_range(0, 255));
               send_item(b, i == n - 1);
            end
         end else begin
            send_dump(($urandom_range(0, 15) == 0) ? '0 : $urandom,
                      1'($urandom_range(0, 1)),
                      $urandom_range(66, 180),
                      ($urandom_range(0, 2) == 0) ? -1 : $urandom_range(0, 20),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0,
                      ($urandom_range(0, 7) == 0),
                      ($urandom_range(0, 9) != 0));
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin
      req_ch.valid       <= 1'b0;
      req_ch.dump_byte   <= '0;
      req_ch.end_of_dump <= 1'b0;
      csr_write_enable   <= 1'b0;
      csr_write_data     <= '0;
      clear_stream();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_search_extremes();
      test_lock_and_samples();
      test_lock_on_final_byte();
      test_failing_pairs();
      test_required_extremes();
      test_random_stream();

      wait_drained();
      if (error_count == 0) begin
         $display("tb_prbs_locked_sample_extractor: PASS");
      end else begin
         $display("tb_prbs_locked_sample_extractor: FAIL");
      end
      $finish;
   end

endmodule
